>>> src/hba_pkg.sv
// hba_pkg: shared constants for the heap block allocator
// default geometry, port field widths, command, status and register codes
// no dependencies
package hba_pkg;

    localparam int HEAP_MAX_DEF     = 8192;
    localparam int GRANULE_DEF      = 16;
    localparam int HEADER_BYTES_DEF = 16;

    localparam int REQ_W     = 14;
    localparam int OFF_W     = 13;
    localparam int STATUS_W  = 3;
    localparam int GB_W      = 14;
    localparam int CFG_W     = 14;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FIT      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_OFFSET  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd4;

    localparam logic REG_HEAP_BYTES = 1'b0;
    localparam logic REG_FIT_POLICY = 1'b1;

endpackage

>>> src/hba_ram.sv
// hba_ram: generic single write port, single read port ram
// read data is registered; no dependencies
module hba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/heap_block_allocator_top.sv
// heap_block_allocator_top: first fit / best fit allocator over a chain of headed blocks
// allocate walks the chain and writes headers; free merges with free neighbours; accepts
// one word at a time; the walk reads one header per cycle from the header ram
// reset and every heap_bytes write run a clearing pass over all HEAP_MAX/GRANULE entries, not ready then
// aresetn is synchronous, active low; depends on hba_pkg and hba_ram
module heap_block_allocator_top #(
    parameter int HEAP_MAX     = hba_pkg::HEAP_MAX_DEF,
    parameter int GRANULE      = hba_pkg::GRANULE_DEF,
    parameter int HEADER_BYTES = hba_pkg::HEADER_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // req_bytes [13:0], data_offset [26:14], zero pad
    input  logic [hba_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // cmd [0]
    input  logic [0:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // status [2:0], offset [15:3], granted_bytes [29:16], zero pad
    output logic [hba_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [0:0]                    cfg_index,
    input  logic [hba_pkg::CFG_W-1:0]     cfg_data
);
    import hba_pkg::*;

    localparam int NGRAN    = HEAP_MAX / GRANULE;
    localparam int LG       = $clog2(GRANULE);
    localparam int HSPAN    = ((HEADER_BYTES + GRANULE - 1) / GRANULE) * GRANULE;
    localparam int HMAX_EFF = NGRAN * GRANULE;
    localparam int AW       = $clog2(HEAP_MAX + 1);
    localparam int SW       = AW + 2;
    localparam int GIW      = $clog2(NGRAN);
    localparam int EW       = AW + 2;

    localparam logic [SW-1:0] HSPAN_S = SW'(HSPAN);
    localparam logic [SW-1:0] HMAX_S  = SW'(HEAP_MAX);
    localparam logic [SW-1:0] HEFF_S  = SW'(HMAX_EFF);
    localparam logic [SW-1:0] GMASK_S = SW'(GRANULE - 1);

    typedef struct packed {
        logic          start;
        logic          free;
        logic [AW-1:0] size;
    } entry_t;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_A_RD  = 13'b0000000000010,
        S_A_EV  = 13'b0000000000100,
        S_A_WR  = 13'b0000000001000,
        S_A_WR2 = 13'b0000000010000,
        S_F_RD  = 13'b0000000100000,
        S_F_EV  = 13'b0000001000000,
        S_F_EVN = 13'b0000010000000,
        S_F_WRE = 13'b0000100000000,
        S_F_WRD = 13'b0001000000000,
        S_F_WEV = 13'b0010000000000,
        S_F_WRU = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } state_t;

    function automatic logic [GIW-1:0] gidx(input logic [SW-1:0] x);
        return x[LG +: GIW];
    endfunction

    state_t              state_reg, state_next;
    logic [SW-1:0]       heap_len_reg, heap_len_next;
    logic                policy_reg, policy_next;
    logic                clr_active_reg, clr_active_next;
    logic [GIW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [SW-1:0]       cur_reg, cur_next;
    logic [SW-1:0]       hdr_reg, hdr_next;
    logic [SW-1:0]       r_reg, r_next;
    logic [SW-1:0]       pick_reg, pick_next;
    logic [SW-1:0]       psize_reg, psize_next;
    logic [SW-1:0]       esize_reg, esize_next;
    logic                found_reg, found_next;
    logic [STATUS_W-1:0] pst_reg, pst_next;
    logic [OFF_W-1:0]    poff_reg, poff_next;
    logic [GB_W-1:0]     pgb_reg, pgb_next;
    logic                mval_reg, mval_next;
    logic [M_TDATA_W-1:0] mdata_reg, mdata_next;

    logic           ram_we;
    logic [GIW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0]  ram_wdata, ram_rdata;
    entry_t         rd_e, wr_e;

    logic [SW-1:0]  hcfg;
    logic [SW-1:0]  reqx, offx, hdrx, esz, base, nxt_s, ncur;
    logic           in_acc, take, hit, split;

    hba_ram #(.WIDTH(EW), .DEPTH(NGRAN)) u_hdr_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && !clr_active_reg;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = mval_reg;
    assign m_axis_tdata  = mdata_reg;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign rd_e          = entry_t'(ram_rdata);

    // heap length from a heap_bytes write: clamp, round up, at least one header
    always_comb begin
        hcfg = SW'(cfg_data);
        if (hcfg == '0) begin
            hcfg = SW'(1);
        end
        if (hcfg > HMAX_S) begin
            hcfg = HMAX_S;
        end
        hcfg = (hcfg + GMASK_S) & ~GMASK_S;
        if (hcfg > HEFF_S) begin
            hcfg = HEFF_S;
        end
        if (hcfg < HSPAN_S) begin
            hcfg = HSPAN_S;
        end
    end

    // shared next-block adder
    always_comb begin
        esz   = SW'(rd_e.size);
        base  = (state_reg == S_F_EV) ? hdr_reg : cur_reg;
        nxt_s = base + HSPAN_S + esz;
        ncur  = (nxt_s + HSPAN_S >= heap_len_reg) ? heap_len_reg : nxt_s;
    end

    always_comb begin
        reqx = SW'(s_axis_tdata[REQ_W-1:0]);
        offx = SW'(s_axis_tdata[REQ_W +: OFF_W]);
        hdrx = offx - HSPAN_S;
        hit  = rd_e.free && (esz >= r_reg);
        take = hit && (!found_reg || (policy_reg && esz < psize_reg));
        split = psize_reg >= r_reg + HSPAN_S + HSPAN_S;
    end

    always_comb begin
        state_next      = state_reg;
        heap_len_next   = heap_len_reg;
        policy_next     = policy_reg;
        clr_active_next = clr_active_reg;
        clr_cnt_next    = clr_cnt_reg;
        cur_next        = cur_reg;
        hdr_next        = hdr_reg;
        r_next          = r_reg;
        pick_next       = pick_reg;
        psize_next      = psize_reg;
        esize_next      = esize_reg;
        found_next      = found_reg;
        pst_next        = pst_reg;
        poff_next       = poff_reg;
        pgb_next        = pgb_reg;
        mval_next       = mval_reg;
        mdata_next      = mdata_reg;
        ram_we          = 1'b0;
        wr_e            = '0;
        ram_waddr       = gidx(cur_reg);
        ram_raddr       = gidx(cur_reg);

        if (mval_reg && m_axis_tready) begin
            mval_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    pst_next  = ST_OK;
                    poff_next = '0;
                    pgb_next  = '0;
                    if (s_axis_tuser[0] == CMD_ALLOC) begin
                        if (reqx == '0 || reqx > heap_len_reg) begin
                            pst_next   = ST_BAD_SIZE;
                            state_next = S_OUT;
                        end else begin
                            r_next     = (reqx + GMASK_S) & ~GMASK_S;
                            cur_next   = '0;
                            found_next = 1'b0;
                            state_next = S_A_RD;
                        end
                    end else begin
                        if (offx < HSPAN_S || hdrx >= heap_len_reg
                                || (hdrx & GMASK_S) != '0) begin
                            pst_next   = ST_BAD_OFFSET;
                            state_next = S_OUT;
                        end else begin
                            hdr_next   = hdrx;
                            state_next = S_F_RD;
                        end
                    end
                end
            end
            S_A_RD: begin
                state_next = S_A_EV;
            end
            S_A_EV: begin
                if (take) begin
                    pick_next  = cur_reg;
                    psize_next = esz;
                    found_next = 1'b1;
                end
                if (hit && !policy_reg) begin
                    state_next = S_A_WR;
                end else if (ncur >= heap_len_reg) begin
                    if (found_reg || take) begin
                        state_next = S_A_WR;
                    end else begin
                        pst_next   = ST_NO_FIT;
                        state_next = S_OUT;
                    end
                end else begin
                    cur_next  = ncur;
                    ram_raddr = gidx(ncur);
                end
            end
            S_A_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = gidx(pick_reg);
                wr_e.start = 1'b1;
                wr_e.free  = 1'b0;
                wr_e.size  = split ? r_reg[AW-1:0] : psize_reg[AW-1:0];
                poff_next  = OFF_W'(pick_reg + HSPAN_S);
                pgb_next   = split ? GB_W'(r_reg) : GB_W'(psize_reg);
                state_next = split ? S_A_WR2 : S_OUT;
            end
            S_A_WR2: begin
                ram_we     = 1'b1;
                ram_waddr  = gidx(pick_reg + HSPAN_S + r_reg);
                wr_e.start = 1'b1;
                wr_e.free  = 1'b1;
                wr_e.size  = AW'(psize_reg - r_reg - HSPAN_S);
                state_next = S_OUT;
            end
            S_F_RD: begin
                ram_raddr  = gidx(hdr_reg);
                state_next = S_F_EV;
            end
            S_F_EV: begin
                if (!rd_e.start) begin
                    pst_next   = ST_BAD_OFFSET;
                    state_next = S_OUT;
                end else if (rd_e.free) begin
                    pst_next   = ST_ALREADY_FREE;
                    state_next = S_OUT;
                end else begin
                    esize_next = esz;
                    if (ncur < heap_len_reg) begin
                        cur_next   = ncur;
                        ram_raddr  = gidx(ncur);
                        state_next = S_F_EVN;
                    end else begin
                        state_next = S_F_WRE;
                    end
                end
            end
            S_F_EVN: begin
                // merge with a free successor
                if (rd_e.free) begin
                    esize_next = esize_reg + HSPAN_S + esz;
                    ram_we     = 1'b1;
                    ram_waddr  = gidx(cur_reg);
                    wr_e       = rd_e;
                    wr_e.start = 1'b0;
                end
                state_next = S_F_WRE;
            end
            S_F_WRE: begin
                ram_we     = 1'b1;
                ram_waddr  = gidx(hdr_reg);
                wr_e.start = 1'b1;
                wr_e.free  = 1'b1;
                wr_e.size  = esize_reg[AW-1:0];
                cur_next   = '0;
                state_next = S_F_WRD;
            end
            S_F_WRD: begin
                state_next = S_F_WEV;
            end
            S_F_WEV: begin
                // look for the predecessor of the freed block
                if (nxt_s == hdr_reg && nxt_s + HSPAN_S < heap_len_reg) begin
                    if (rd_e.free) begin
                        ram_we     = 1'b1;
                        ram_waddr  = gidx(cur_reg);
                        wr_e.start = 1'b1;
                        wr_e.free  = 1'b1;
                        wr_e.size  = AW'(esz + HSPAN_S + esize_reg);
                        state_next = S_F_WRU;
                    end else begin
                        state_next = S_OUT;
                    end
                end else if (ncur >= heap_len_reg) begin
                    state_next = S_OUT;
                end else begin
                    cur_next  = ncur;
                    ram_raddr = gidx(ncur);
                end
            end
            S_F_WRU: begin
                ram_we     = 1'b1;
                ram_waddr  = gidx(hdr_reg);
                wr_e.start = 1'b0;
                wr_e.free  = 1'b1;
                wr_e.size  = esize_reg[AW-1:0];
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!mval_reg || m_axis_tready) begin
                    mval_next  = 1'b1;
                    mdata_next = M_TDATA_W'({pgb_reg, poff_reg, pst_reg});
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // clearing pass: entry 0 holds the single free block, the rest are zero
        if (clr_active_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            wr_e      = '0;
            if (clr_cnt_reg == '0) begin
                wr_e.start = 1'b1;
                wr_e.free  = 1'b1;
                wr_e.size  = AW'(heap_len_reg - HSPAN_S);
            end
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == GIW'(NGRAN - 1)) begin
                clr_active_next = 1'b0;
            end
        end

        if (cfg_valid && cfg_ready) begin
            if (cfg_index[0] == REG_HEAP_BYTES) begin
                heap_len_next   = hcfg;
                clr_active_next = 1'b1;
                clr_cnt_next    = '0;
            end else begin
                policy_next = cfg_data[0];
            end
        end
    end

    assign ram_wdata = wr_e;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            heap_len_reg   <= HEFF_S;
            policy_reg     <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            mval_reg       <= 1'b0;
            found_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            heap_len_reg   <= heap_len_next;
            policy_reg     <= policy_next;
            clr_active_reg <= clr_active_next;
            clr_cnt_reg    <= clr_cnt_next;
            mval_reg       <= mval_next;
            found_reg      <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        hdr_reg   <= hdr_next;
        r_reg     <= r_next;
        pick_reg  <= pick_next;
        psize_reg <= psize_next;
        esize_reg <= esize_next;
        pst_reg   <= pst_next;
        poff_reg  <= poff_next;
        pgb_reg   <= pgb_next;
        mdata_reg <= mdata_next;
    end

    a_no_accept_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !s_axis_tready)
        else $error("word accepted during clearing pass");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready held after accepting a word");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(state_reg == S_OUT))
        else $error("result shown outside the output state");

endmodule
